### sv/serial_to_default_passphrase_top_macros.svh
// Assertion macros shared by the passphrase checker.
`ifndef SERIAL_TO_DEFAULT_PASSPHRASE_TOP_MACROS_SVH
`define SERIAL_TO_DEFAULT_PASSPHRASE_TOP_MACROS_SVH
// Asserts that a condition implies a consequence in the same cycle.
`define STP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that a condition implies a consequence in the next cycle.
`define STP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/stp_pkg.sv
// Package with MD5 constants and helper functions for the passphrase block.
`timescale 1ns / 1ps
package stp_pkg;
  localparam int unsigned MD5_ROUNDS = 64;
  localparam int unsigned DEPTH = 2 * MD5_ROUNDS + 4;

  typedef logic [31:0] word_t;
  typedef logic [511:0] block_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } md5_st_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hefcdab89;
  localparam word_t IV_C = 32'h98badcfe;
  localparam word_t IV_D = 32'h10325476;

  function automatic word_t md5_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [5:0] g;
    case (i[5:4])
      2'd0: g = i;
      2'd1: g = 6'(5 * i + 1);
      2'd2: g = 6'(3 * i + 5);
      default: g = 6'(7 * i);
    endcase
    return g[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h37 + 8'(n));
  endfunction

  function automatic logic [7:0] pass_char(input logic [7:0] b);
    logic [4:0] m;
    logic [7:0] v;
    m = b[4:0];
    if (m >= 5'd23) m = m - 5'd23;
    v = 8'h41 + 8'(m);
    if (v >= 8'h49) v = v + 8'd1;
    if (v >= 8'h4c) v = v + 8'd1;
    if (v >= 8'h4f) v = v + 8'd1;
    return v;
  endfunction
endpackage

### sv/stp_md5_cell.sv
// One MD5 round cell: holds the working state and message of one item.
`timescale 1ns / 1ps
module stp_md5_cell #(
  parameter logic [5:0] ROUND = 6'd0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  stp_pkg::md5_st_t st_i,
  input  stp_pkg::block_t  msg_i,
  output logic             vld_o,
  output stp_pkg::md5_st_t st_o,
  output stp_pkg::block_t  msg_o
);
  stp_pkg::word_t f;
  stp_pkg::word_t t;
  stp_pkg::word_t m;
  stp_pkg::word_t rot;
  logic [63:0] dbl;
  stp_pkg::md5_st_t st_nxt;
  stp_pkg::md5_st_t st_r;
  stp_pkg::block_t msg_r;
  logic vld_r;

  always_comb begin
    case (ROUND[5:4])
      2'd0: f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      2'd1: f = (st_i.d & st_i.b) | (~st_i.d & st_i.c);
      2'd2: f = st_i.b ^ st_i.c ^ st_i.d;
      default: f = st_i.c ^ (st_i.b | ~st_i.d);
    endcase
    m = msg_i[32*stp_pkg::md5_g(ROUND) +: 32];
    t = st_i.a + f + stp_pkg::md5_k(ROUND) + m;
    dbl = {t, t} << stp_pkg::md5_s(ROUND);
    rot = dbl[63:32];
    st_nxt.a = st_i.d;
    st_nxt.b = st_i.b + rot;
    st_nxt.c = st_i.b;
    st_nxt.d = st_i.c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    st_r <= st_nxt;
    msg_r <= msg_i;
  end

  assign vld_o = vld_r;
  assign st_o = st_r;
  assign msg_o = msg_r;
endmodule

### sv/stp_md5_chain.sv
// Row of 64 MD5 round cells followed by the final state addition.
`timescale 1ns / 1ps
module stp_md5_chain (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  stp_pkg::block_t msg_i,
  output logic            vld_o,
  output logic [127:0]    dig_o
);
  logic vld_w [0:stp_pkg::MD5_ROUNDS];
  stp_pkg::md5_st_t st_w [0:stp_pkg::MD5_ROUNDS];
  stp_pkg::block_t msg_w [0:stp_pkg::MD5_ROUNDS];
  stp_pkg::word_t a_s;
  stp_pkg::word_t b_s;
  stp_pkg::word_t c_s;
  stp_pkg::word_t d_s;
  logic vld_r;
  logic [127:0] dig_r;

  assign vld_w[0] = vld_i;
  assign st_w[0] = '{stp_pkg::IV_A, stp_pkg::IV_B, stp_pkg::IV_C, stp_pkg::IV_D};
  assign msg_w[0] = msg_i;

  for (genvar gi = 0; gi < stp_pkg::MD5_ROUNDS; gi++) begin : g_cell
    stp_md5_cell #(.ROUND(6'(gi))) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(vld_w[gi]), .st_i(st_w[gi]), .msg_i(msg_w[gi]),
      .vld_o(vld_w[gi+1]), .st_o(st_w[gi+1]), .msg_o(msg_w[gi+1])
    );
  end

  assign a_s = st_w[stp_pkg::MD5_ROUNDS].a + stp_pkg::IV_A;
  assign b_s = st_w[stp_pkg::MD5_ROUNDS].b + stp_pkg::IV_B;
  assign c_s = st_w[stp_pkg::MD5_ROUNDS].c + stp_pkg::IV_C;
  assign d_s = st_w[stp_pkg::MD5_ROUNDS].d + stp_pkg::IV_D;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_w[stp_pkg::MD5_ROUNDS];
    end
    dig_r <= {d_s, c_s, b_s, a_s};
  end

  assign vld_o = vld_r;
  assign dig_o = dig_r;
endmodule

### sv/stp_fold.sv
// Folds the first digest into two words, two pipeline stages.
`timescale 1ns / 1ps
module stp_fold (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [127:0] dig_i,
  output logic         vld_o,
  output stp_pkg::block_t msg_o
);
  logic [1:0] vld_r;
  logic [31:0] b_r [0:1];
  logic [31:0] s_r [0:1];
  logic [31:0] w_r [0:1];
  logic [31:0] b_nxt [0:1];
  logic [31:0] s_nxt [0:1];
  logic [31:0] w_nxt [0:1];

  always_comb begin
    logic [15:0] w0, w1, w2, w3;
    logic [16:0] q;
    for (int k = 0; k < 2; k++) begin
      w0 = dig_i[64*k +: 16];
      w1 = dig_i[64*k+16 +: 16];
      w2 = dig_i[64*k+32 +: 16];
      w3 = dig_i[64*k+48 +: 16];
      q = {1'b0, w3};
      while_loop: for (int j = 0; j < 6; j++) begin
        if (q >= 17'd9999) q = q - 17'd9999;
      end
      b_nxt[k] = 32'(({15'd0, q} + 32'd1) * 32'd11);
      s_nxt[k] = 32'({16'd0, w1} * 32'd100 + {16'd0, w2} * 32'd10 + {16'd0, w0});
      w_nxt[k] = 32'(b_r[k] * s_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], vld_i};
    end
    for (int k = 0; k < 2; k++) begin
      b_r[k] <= b_nxt[k];
      s_r[k] <= s_nxt[k];
      w_r[k] <= w_nxt[k];
    end
  end

  always_comb begin
    msg_o = '0;
    for (int i = 0; i < 8; i++) begin
      msg_o[8*i +: 8] = stp_pkg::hex_char(w_r[0][28-4*i +: 4]);
      msg_o[64+8*i +: 8] = stp_pkg::hex_char(w_r[1][28-4*i +: 4]);
    end
    msg_o[135:128] = 8'h80;
    msg_o[455:448] = 8'd128;
  end

  assign vld_o = vld_r[1];
endmodule

### sv/serial_to_default_passphrase_top.sv
// Top level: serial to default passphrase, a pipeline of two MD5 cell chains.
// One item is accepted per cycle (busy stays low). Its passphrase is on
// out_passphrase, with out_valid, for one cycle, after it has passed the
// 133 register stages: one input stage, two rows of 64 MD5 round cells
// plus one digest stage each, and two fold stages. The receiver cannot
// stall, so results must be taken.
`timescale 1ns / 1ps
module serial_to_default_passphrase_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_group_a,
  input  logic [6:0]  in_group_b,
  input  logic [3:0]  in_group_c,
  input  logic [13:0] in_group_d,
  input  logic [1:0]  in_band_mode,
  output logic        out_valid,
  output logic [63:0] out_passphrase
);
  logic vld_r;
  stp_pkg::block_t msg_r;
  stp_pkg::block_t msg_nxt;
  logic v1, v2, v3;
  logic [127:0] d1, d2;
  stp_pkg::block_t m2;
  logic [63:0] pass;

  always_comb begin
    logic [3:0] a, c;
    logic [6:0] b;
    logic [13:0] d;
    logic [7:0] ser [0:11];
    logic [31:0] bq, q10, q100, q1000;
    a = (in_group_a > 4'd9) ? 4'd9 : in_group_a;
    b = (in_group_b > 7'd99) ? 7'd99 : in_group_b;
    c = (in_group_c > 4'd9) ? 4'd9 : in_group_c;
    d = (in_group_d > 14'd9999) ? 14'd9999 : in_group_d;
    bq = (32'(b) * 32'd205) >> 11;
    q10 = (32'(d) * 32'd52429) >> 19;
    q100 = (32'(d) * 32'd5243) >> 19;
    q1000 = (32'(d) * 32'd8389) >> 23;
    ser[0] = 8'h53; ser[1] = 8'h41; ser[2] = 8'h41; ser[3] = 8'h50;
    ser[4] = 8'h30 + 8'(a);
    ser[5] = 8'h30 + bq[7:0];
    ser[6] = 8'h30 + 8'(32'(b) - bq * 32'd10);
    ser[7] = 8'h30 + 8'(c);
    ser[8] = 8'h30 + q1000[7:0];
    ser[9] = 8'h30 + 8'(q100 - q1000 * 32'd10);
    ser[10] = 8'h30 + 8'(q10 - q100 * 32'd10);
    ser[11] = 8'h30 + 8'(32'(d) - q10 * 32'd10);
    msg_nxt = '0;
    for (int i = 0; i < 12; i++) begin
      msg_nxt[8*i +: 8] = (in_band_mode == 2'd2) ? ser[11-i] : ser[i];
    end
    msg_nxt[103:96] = 8'h80;
    msg_nxt[455:448] = 8'd96;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
    msg_r <= msg_nxt;
  end

  stp_md5_chain u_md5_a (
    .clk(clk), .rst_n(rst_n), .vld_i(vld_r), .msg_i(msg_r), .vld_o(v1), .dig_o(d1)
  );

  stp_fold u_fold (
    .clk(clk), .rst_n(rst_n), .vld_i(v1), .dig_i(d1), .vld_o(v2), .msg_o(m2)
  );

  stp_md5_chain u_md5_b (
    .clk(clk), .rst_n(rst_n), .vld_i(v2), .msg_i(m2), .vld_o(v3), .dig_o(d2)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pass[8*i +: 8] = stp_pkg::pass_char(d2[8*i +: 8]);
    end
  end

  assign busy = 1'b0;
  assign out_valid = v3;
  assign out_passphrase = pass;
endmodule

### sv/stp_checker.sv
// Port checker for the passphrase block, bound to the top level.
`timescale 1ns / 1ps
`include "serial_to_default_passphrase_top_macros.svh"
module stp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_passphrase
);
  `STP_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `STP_ASSERT_NXT(a_reset_quiet, !rst_n, !out_valid)
  `STP_ASSERT_IMP(a_upper_low, out_valid, out_passphrase[7:5] == 3'b010)
  `STP_ASSERT_IMP(a_upper_high, out_valid, out_passphrase[63:61] == 3'b010)
  `STP_ASSERT_IMP(a_latency, start && !busy, ##133 out_valid)
endmodule

bind serial_to_default_passphrase_top stp_checker u_stp_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_passphrase(out_passphrase)
);

### tb/serial_to_default_passphrase_top_test.sv
// Self-checking testbench for the serial to default passphrase block.
`timescale 1ns / 1ps
module serial_to_default_passphrase_top_test;
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                  6, 10, 15, 21};
  localparam logic [1:0] MODE_REVERSED = 2'd2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  class passphrase_scoreboard;
    logic [63:0] pending_phrases [$];
    int mismatches = 0;

    function logic [127:0] md5_digest(logic [7:0] msg [16], int len);
      logic [7:0] blk [64];
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t, sum;
      logic [127:0] dig;
      logic [63:0] bits;
      int i, g, s;
      bits = 64'(len) * 8;
      for (i = 0; i < 64; i++) blk[i] = 8'h00;
      for (i = 0; i < len; i++) blk[i] = msg[i];
      blk[len] = 8'h80;
      for (i = 0; i < 8; i++) blk[56 + i] = bits[8 * i +: 8];
      for (i = 0; i < 16; i++) m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
      for (i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d); g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d; g = (3 * i + 5) % 16;
        end else begin
          f = c ^ (b | ~d); g = (7 * i) % 16;
        end
        s = ROT_AMT[((i / 16) * 4) + (i % 4)];
        sum = a + f + ROUND_K[i] + m[g];
        t = d; d = c; c = b;
        b = b + ((sum << s) | (sum >> (32 - s)));
        a = t;
      end
      a = a + 32'h67452301; b = b + 32'hefcdab89;
      c = c + 32'h98badcfe; d = d + 32'h10325476;
      dig = {d, c, b, a};
      return dig;
    endfunction

    function logic [31:0] fold_half(logic [63:0] half);
      logic [63:0] w0, w1, w2, w3, mult, sel, prod;
      w0 = 64'(half[15:0]); w1 = 64'(half[31:16]);
      w2 = 64'(half[47:32]); w3 = 64'(half[63:48]);
      mult = (((w3 % 9999) + 1) * 11) & 64'hffffffff;
      sel = (w1 * 100 + w2 * 10 + w0) & 64'hffffffff;
      prod = mult * sel;
      return prod[31:0];
    endfunction

    function logic [63:0] predict_phrase(logic [3:0] ga, logic [6:0] gb,
                                         logic [3:0] gc, logic [13:0] gd,
                                         logic [1:0] mode);
      logic [7:0] serial [16];
      logic [7:0] msg [16];
      logic [127:0] dig;
      logic [31:0] folded [2];
      logic [3:0] nib;
      logic [7:0] v;
      logic [63:0] phrase;
      int i, k, na, nb, nc, nd;
      na = (ga > 9) ? 9 : ga;
      nb = (gb > 99) ? 99 : gb;
      nc = (gc > 9) ? 9 : gc;
      nd = (gd > 9999) ? 9999 : gd;
      for (i = 0; i < 16; i++) begin
        serial[i] = 8'h00; msg[i] = 8'h00;
      end
      serial[0] = "S"; serial[1] = "A"; serial[2] = "A"; serial[3] = "P";
      serial[4] = 8'(8'h30 + na);
      serial[5] = 8'(8'h30 + nb / 10);
      serial[6] = 8'(8'h30 + nb % 10);
      serial[7] = 8'(8'h30 + nc);
      serial[8] = 8'(8'h30 + nd / 1000);
      serial[9] = 8'(8'h30 + (nd / 100) % 10);
      serial[10] = 8'(8'h30 + (nd / 10) % 10);
      serial[11] = 8'(8'h30 + nd % 10);
      for (i = 0; i < 12; i++) msg[i] = (mode == MODE_REVERSED) ? serial[11 - i] : serial[i];
      dig = md5_digest(msg, 12);
      folded[0] = fold_half(dig[63:0]);
      folded[1] = fold_half(dig[127:64]);
      for (k = 0; k < 2; k++)
        for (i = 0; i < 8; i++) begin
          nib = folded[k][28 - 4 * i +: 4];
          msg[8 * k + i] = (nib < 10) ? 8'(8'h30 + nib) : 8'(8'h37 + nib);
        end
      dig = md5_digest(msg, 16);
      for (i = 0; i < 8; i++) begin
        v = 8'((dig[8 * i +: 5]) % 23) + 8'h41;
        if (v >= "I") v++;
        if (v >= "L") v++;
        if (v >= "O") v++;
        phrase[8 * i +: 8] = v;
      end
      return phrase;
    endfunction

    function void note_serial(logic [3:0] ga, logic [6:0] gb, logic [3:0] gc,
                              logic [13:0] gd, logic [1:0] mode);
      pending_phrases.push_back(predict_phrase(ga, gb, gc, gd, mode));
    endfunction

    function void check_phrase(logic [63:0] actual);
      logic [63:0] want;
      if (pending_phrases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected passphrase %h", actual);
      end else begin
        want = pending_phrases.pop_front();
        if (actual !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Passphrase mismatch: expected %h actual %h", want, actual);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_group_a = '0;
  logic [6:0] in_group_b = '0;
  logic [3:0] in_group_c = '0;
  logic [13:0] in_group_d = '0;
  logic [1:0] in_band_mode = '0;
  logic out_valid;
  logic [63:0] out_passphrase;
  passphrase_scoreboard sb = new();
  int idle_cycles = 0;

  serial_to_default_passphrase_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_group_a(in_group_a), .in_group_b(in_group_b), .in_group_c(in_group_c),
    .in_group_d(in_group_d), .in_band_mode(in_band_mode),
    .out_valid(out_valid), .out_passphrase(out_passphrase)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_serial(in_group_a, in_group_b, in_group_c, in_group_d, in_band_mode);
    if (rst_n && out_valid) sb.check_phrase(out_passphrase);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_serial(logic [3:0] ga, logic [6:0] gb, logic [3:0] gc,
                             logic [13:0] gd, logic [1:0] mode);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 150);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_group_a <= ga; in_group_b <= gb; in_group_c <= gc;
    in_group_d <= gd; in_band_mode <= mode;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int i, m, burst;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (m = 0; m < 4; m++) begin
      send_serial(4'd0, 7'd0, 4'd0, 14'd0, 2'(m));
      send_serial(4'd9, 7'd99, 4'd9, 14'd9999, 2'(m));
      send_serial(4'd15, 7'd127, 4'd15, 14'd16383, 2'(m));
    end
    send_serial(4'd1, 7'd23, 4'd4, 14'd5678, 2'd0);
    send_serial(4'd1, 7'd23, 4'd4, 14'd5678, 2'd2);
    send_serial(4'd10, 7'd100, 4'd10, 14'd10000, 2'd2);
    send_serial(4'd5, 7'd5, 4'd3, 14'd7, 2'd1);
    send_serial(4'd0, 7'd9, 4'd0, 14'd99, 2'd3);
    i = 0;
    while (i < 1150) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 8)
          send_serial(4'($urandom_range(0, 9)), 7'($urandom_range(0, 99)),
                      4'($urandom_range(0, 9)), 14'($urandom_range(0, 9999)),
                      2'($urandom_range(0, 3)));
        else
          send_serial(4'($urandom), 7'($urandom), 4'($urandom), 14'($urandom),
                      2'($urandom));
        i++;
      end
    end
    start <= 1'b0;
    while (sb.pending_phrases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_phrases.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
